// ===== src/indexed_ordered_list_defines.svh =====
// Assertion macros for the indexed ordered list.
`ifndef INDEXED_ORDERED_LIST_DEFINES_SVH
`define INDEXED_ORDERED_LIST_DEFINES_SVH
`ifndef SYNTHESIS
`define IOL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IOL_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IOL_ASSERT(label, clk, rst_n, prop, msg)
`define IOL_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== src/iol_pkg.sv =====
// Shared types and constants for the indexed ordered list.
package iol_pkg;
    localparam int unsigned CapacityDefault = 64;
    localparam int unsigned ModeW = 3;
    localparam int unsigned PosW = 10;
    localparam int unsigned ValW = 32;
    localparam int unsigned LenW = 11;
    localparam int unsigned StW = 2;

    localparam logic [ModeW-1:0] MODE_GET  = 3'd0;
    localparam logic [ModeW-1:0] MODE_HEAD = 3'd1;
    localparam logic [ModeW-1:0] MODE_TAIL = 3'd2;
    localparam logic [ModeW-1:0] MODE_AT   = 3'd3;
    localparam logic [ModeW-1:0] MODE_DEL  = 3'd4;

    localparam logic [StW-1:0] ST_DONE  = 2'd0;
    localparam logic [StW-1:0] ST_RANGE = 2'd1;
    localparam logic [StW-1:0] ST_FULL  = 2'd2;

    localparam logic [ValW-1:0] NotFoundValue = '1;

    // one memory port request: read and/or write at one address each
    typedef struct packed {
        logic            rd_en;
        logic [PosW-1:0] rd_addr;
        logic            wr_en;
        logic [PosW-1:0] wr_addr;
        logic [ValW-1:0] wr_data;
    } t_mem_req;
endpackage

// ===== src/iol_mem.sv =====
// Single-port-write, single-port-read store of list entries.
module iol_mem import iol_pkg::*; #(
    parameter int unsigned CAPACITY = CapacityDefault
) (
    input  logic            i_clk,
    input  t_mem_req        i_req,
    output logic [ValW-1:0] o_rd_data
);
    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [ValW-1:0] r_mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr[AW-1:0]] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            o_rd_data <= r_mem[i_req.rd_addr[AW-1:0]];
        end
    end
endmodule

// ===== src/iol_ctrl.sv =====
// Sequencer: decodes a request, shifts entries by a read then a write each, and answers.
module iol_ctrl import iol_pkg::*; #(
    parameter int unsigned CAPACITY = CapacityDefault
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [ModeW-1:0]  i_mode,
    input  logic [PosW-1:0]   i_position,
    input  logic [ValW-1:0]   i_item_value,
    output t_mem_req          o_mem_req,
    input  logic [ValW-1:0]   i_rd_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ValW-1:0]   o_read_value,
    output logic              o_found,
    output logic [StW-1:0]    o_status,
    output logic [LenW-1:0]   o_list_length
);
    `include "indexed_ordered_list_defines.svh"

    localparam logic [LenW-1:0] Cap = LenW'(CAPACITY);

    typedef enum logic [2:0] {S_IDLE, S_GETW, S_INS, S_DEL, S_LAST} t_state;

    t_state          r_state;
    logic [LenW-1:0] r_len;
    logic [LenW-1:0] r_idx;    // current slot being moved
    logic [LenW-1:0] r_stop;
    logic [ValW-1:0] r_val;
    logic            r_rd_pend;

    logic            acc;
    logic [LenW-1:0] pos_ext;
    assign pos_ext = LenW'(i_position);
    assign acc = i_valid && o_ready;
    // output register frees before the next request
    assign o_ready = (r_state == S_IDLE) && (!o_valid || i_ready);

    // memory request: insert moves entry idx-1 to idx; delete moves idx+1 to idx.
    always_comb begin
        o_mem_req = '0;
        case (r_state)
            S_IDLE: begin
                o_mem_req.rd_en   = acc && (i_mode == MODE_GET);
                o_mem_req.rd_addr = i_position;
            end
            S_INS: begin
                if (r_idx != r_stop) begin
                    o_mem_req.rd_en   = !r_rd_pend;
                    o_mem_req.rd_addr = PosW'(r_idx - 1'b1);
                    o_mem_req.wr_en   = r_rd_pend;
                    o_mem_req.wr_addr = PosW'(r_idx);
                    o_mem_req.wr_data = i_rd_data;
                end
            end
            S_DEL: begin
                if (r_idx + 1'b1 < r_len) begin
                    o_mem_req.rd_en   = !r_rd_pend;
                    o_mem_req.rd_addr = PosW'(r_idx + 1'b1);
                    o_mem_req.wr_en   = r_rd_pend;
                    o_mem_req.wr_addr = PosW'(r_idx);
                    o_mem_req.wr_data = i_rd_data;
                end
            end
            S_LAST: begin
                o_mem_req.wr_en   = 1'b1;
                o_mem_req.wr_addr = PosW'(r_stop);
                o_mem_req.wr_data = r_val;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        logic n_valid;
        n_valid = o_valid && !i_ready;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= '0;
            r_rd_pend <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        o_read_value  <= NotFoundValue;
                        o_found       <= 1'b0;
                        o_list_length <= r_len;
                        r_val         <= i_item_value;
                        r_rd_pend     <= 1'b0;
                        case (i_mode)
                            MODE_GET: begin
                                if (pos_ext < r_len) begin
                                    o_status <= ST_DONE;
                                    r_state  <= S_GETW;
                                end else begin
                                    o_status <= ST_RANGE;
                                    n_valid  = 1'b1;
                                end
                            end
                            MODE_HEAD, MODE_TAIL, MODE_AT: begin
                                r_idx <= r_len;
                                if (i_mode == MODE_AT && pos_ext > r_len) begin
                                    o_status <= ST_RANGE;
                                    n_valid  = 1'b1;
                                end else if (r_len >= Cap) begin
                                    o_status <= ST_FULL;
                                    n_valid  = 1'b1;
                                end else begin
                                    o_status <= ST_DONE;
                                    r_stop   <= (i_mode == MODE_HEAD) ? '0 :
                                                (i_mode == MODE_TAIL) ? r_len : pos_ext;
                                    r_state  <= S_INS;
                                end
                            end
                            MODE_DEL: begin
                                r_idx <= pos_ext;
                                if (pos_ext >= r_len) begin
                                    o_status <= ST_RANGE;
                                    n_valid  = 1'b1;
                                end else begin
                                    o_status <= ST_DONE;
                                    r_state  <= S_DEL;
                                end
                            end
                            default: begin
                                o_status <= ST_DONE;
                                n_valid  = 1'b1;
                            end
                        endcase
                    end
                end
                S_GETW: begin
                    o_read_value <= i_rd_data;
                    o_found      <= 1'b1;
                    n_valid      = 1'b1;
                    r_state      <= S_IDLE;
                end
                S_INS: begin
                    if (r_idx == r_stop) r_state <= S_LAST;
                    else if (r_rd_pend) begin
                        r_rd_pend <= 1'b0;
                        r_idx     <= r_idx - 1'b1;
                    end else r_rd_pend <= 1'b1;
                end
                S_LAST: begin
                    r_len         <= r_len + 1'b1;
                    o_list_length <= r_len + 1'b1;
                    n_valid       = 1'b1;
                    r_state       <= S_IDLE;
                end
                S_DEL: begin
                    if (r_idx + 1'b1 >= r_len) begin
                        r_len         <= r_len - 1'b1;
                        o_list_length <= r_len - 1'b1;
                        n_valid       = 1'b1;
                        r_state       <= S_IDLE;
                    end else if (r_rd_pend) begin
                        r_rd_pend <= 1'b0;
                        r_idx     <= r_idx + 1'b1;
                    end else r_rd_pend <= 1'b1;
                end
                default: r_state <= S_IDLE;
            endcase
            o_valid <= n_valid;
        end
    end

    `IOL_ASSERT(a_len_cap, i_clk, i_rst_n, r_len <= Cap, "length above capacity")
    `IOL_ASSERT(a_busy_not_ready, i_clk, i_rst_n, (r_state != S_IDLE) |-> !o_ready,
                "ready while busy")
    `IOL_ASSERT(a_found_ok, i_clk, i_rst_n, (o_valid && o_found) |-> (o_status == ST_DONE),
                "found with bad status")
    `IOL_ASSERT(a_len_step, i_clk, i_rst_n,
                (r_len != $past(r_len)) |-> (r_state == S_IDLE && o_valid),
                "length changed without result")
endmodule

// ===== src/indexed_ordered_list.sv =====
// Indexed ordered list, top level.
// Get reads one entry from the store. Insert at p shifts entries p..len-1 up one slot and
// then writes the item at p; delete at p shifts the entries above p down one slot.
// Each shifted entry costs one memory read plus one write through the single store.
// One request at a time; the next is taken once the result register is free.
// Synchronous active-low reset empties the list; entry contents are not cleared.
module indexed_ordered_list import iol_pkg::*; #(
    parameter int unsigned CAPACITY = CapacityDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // mode[2:0], position[12:3], item_value[44:13]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // read_value[31:0], found[32], status[34:33],
                                        // list_length[45:35]
);
    t_mem_req        mem_req;
    logic [ValW-1:0] rd_data;
    logic [ValW-1:0] read_value;
    logic            found;
    logic [StW-1:0]  status;
    logic [LenW-1:0] list_length;

    iol_mem #(.CAPACITY(CAPACITY)) u_mem (
        .i_clk(i_clk), .i_req(mem_req), .o_rd_data(rd_data)
    );

    iol_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_mode(s_axis_tdata[2:0]), .i_position(s_axis_tdata[12:3]),
        .i_item_value(s_axis_tdata[44:13]),
        .o_mem_req(mem_req), .i_rd_data(rd_data),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_read_value(read_value), .o_found(found), .o_status(status),
        .o_list_length(list_length)
    );

    assign m_axis_tdata = {2'b00, list_length, status, found, read_value};
endmodule

// ===== dv/iol_checker.sv =====
// Checker for the indexed ordered list: predicts each result and compares it.
module iol_checker import iol_pkg::*; #(
    parameter int unsigned CAPACITY = CapacityDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [47:0] i_req_data,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [47:0] i_rsp_data,
    output int          o_fail_count,
    output int          o_pending
);
    typedef struct packed {
        logic [LenW-1:0] list_length;
        logic [StW-1:0]  status;
        logic            found;
        logic [ValW-1:0] read_value;
    } t_answer;

    logic [ValW-1:0] list_q[$];
    t_answer         answer_q[$];

    assign o_pending = answer_q.size();

    function automatic t_answer apply_request(logic [47:0] req);
        t_answer         a;
        logic [ModeW-1:0] mode;
        int              pos;
        int              at;
        logic [ValW-1:0] val;
        mode = req[2:0];
        pos  = int'(req[12:3]);
        val  = req[44:13];
        a.read_value = NotFoundValue;
        a.found = 1'b0;
        a.status = ST_DONE;
        at = -1;
        case (mode)
            MODE_GET: begin
                if (pos < list_q.size()) begin
                    a.read_value = list_q[pos];
                    a.found = 1'b1;
                end else a.status = ST_RANGE;
            end
            MODE_HEAD: at = 0;
            MODE_TAIL: at = list_q.size();
            MODE_AT:   at = pos;
            MODE_DEL: begin
                if (pos < list_q.size()) list_q.delete(pos);
                else a.status = ST_RANGE;
            end
            default: ;
        endcase
        if (at >= 0) begin
            // range test wins over full
            if (at > list_q.size()) a.status = ST_RANGE;
            else if (list_q.size() >= CAPACITY) a.status = ST_FULL;
            else list_q.insert(at, val);
        end
        a.list_length = LenW'(list_q.size());
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        t_answer got;
        if (!i_rst_n) begin
            list_q.delete();
            answer_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                got = i_rsp_data[45:0];
                if (answer_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = answer_q.pop_front();
                    if (got !== want || i_rsp_data[47:46] !== 2'b0) begin
                        $display("%0t: mismatch expected val=%h found=%b st=%0d len=%0d",
                                 $time, want.read_value, want.found, want.status,
                                 want.list_length);
                        $display("%0t:          actual   val=%h found=%b st=%0d len=%0d",
                                 $time, got.read_value, got.found, got.status,
                                 got.list_length);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_req_valid && i_req_ready) answer_q.push_back(apply_request(i_req_data));
        end
    end
endmodule

// ===== dv/testbench.sv =====
// Testbench top: drives requests into the indexed ordered list and gives the verdict.
module testbench;
    import iol_pkg::*;

    localparam int Cap = CapacityDefault;
    localparam int CycleLimit = 3_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [47:0] s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [47:0] m_data;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    bit          quiet = 1'b0;
    int          len_est = 0;

    always #2 i_clk = ~i_clk;

    indexed_ordered_list #(.CAPACITY(Cap)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data)
    );

    iol_checker #(.CAPACITY(Cap)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(s_valid), .i_req_ready(s_ready), .i_req_data(s_data),
        .i_rsp_valid(m_valid), .i_rsp_ready(m_ready), .i_rsp_data(m_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver stalls in bursts
    always @(negedge i_clk) begin
        int stall;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(1, 4);
            m_ready <= 1'b0;
            repeat (stall) @(negedge i_clk);
        end
        m_ready <= 1'b1;
    end

    task automatic send_request(logic [ModeW-1:0] mode, int pos, logic [ValW-1:0] val);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_data <= {3'b0, val, pos[PosW-1:0], mode};
        s_valid <= 1'b1;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        @(negedge i_clk);
        // rough length tracking only steers the random mix
        case (mode)
            MODE_HEAD, MODE_TAIL: if (len_est < Cap) len_est++;
            MODE_AT: if (pos <= len_est && len_est < Cap) len_est++;
            MODE_DEL: if (pos < len_est) len_est--;
            default: ;
        endcase
    endtask

    task automatic random_request(int fill_bias);
        logic [ModeW-1:0] mode;
        int pos;
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) mode = 3'($urandom_range(5, 7));
        else if (r < 22) mode = MODE_GET;
        else if (r < 22 + fill_bias) mode = 3'($urandom_range(MODE_HEAD, MODE_AT));
        else mode = MODE_DEL;
        if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, 1023);
        else pos = $urandom_range(0, len_est);
        send_request(mode, pos, $urandom());
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // empty and short list corner cases, including unused modes
        send_request(MODE_GET, 0, 32'h0);
        send_request(MODE_DEL, 0, 32'h0);
        send_request(MODE_AT, 1, 32'h1234);
        send_request(MODE_AT, 1023, 32'hFFFF_FFFF);
        send_request(MODE_AT, 0, 32'h8000_0000);
        send_request(MODE_HEAD, 1023, 32'h7FFF_FFFF);
        send_request(MODE_TAIL, 0, 32'hFFFF_FFFF);
        send_request(MODE_AT, 3, 32'h0);
        send_request(MODE_GET, 0, 32'h0);
        send_request(MODE_GET, 3, 32'h0);
        send_request(MODE_GET, 4, 32'h0);
        send_request(MODE_GET, 1023, 32'h0);
        send_request(3'd5, 1023, 32'hFFFF_FFFF);
        send_request(3'd6, 0, 32'h0);
        send_request(3'd7, 2, 32'h5555_5555);
        send_request(MODE_DEL, 3, 32'h0);
        send_request(MODE_DEL, 4, 32'h0);
        send_request(MODE_DEL, 0, 32'h0);
        send_request(MODE_GET, 1, 32'h0);
        // fill to capacity, then probe full and range behavior
        while (len_est < Cap) send_request(MODE_TAIL, 0, $urandom());
        send_request(MODE_HEAD, 0, 32'h1);
        send_request(MODE_TAIL, 0, 32'h2);
        send_request(MODE_AT, Cap, 32'h3);
        send_request(MODE_AT, Cap + 1, 32'h4);
        send_request(MODE_GET, Cap - 1, 32'h0);
        send_request(MODE_GET, Cap, 32'h0);
        // hold off until every answer is back
        s_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        for (int i = 0; i < 1300; i++) begin
            random_request(i % 400 < 200 ? 55 : 30);
            if (i == 1150) quiet = 1'b1;
        end
        s_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (2 * Cap + 20) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule
